/* rtl/tdp_pkg.sv */
`default_nettype none
package tdp_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_DOT   = 8'd46;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_COLON = 8'd58;

    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [2:0] FRAC_PLACES = 3'd6;

    localparam int unsigned TIME_W  = 37;
    localparam int unsigned FRAC_W  = 20;
    localparam int unsigned MINS_W  = 13;
    localparam int unsigned SECS_W  = 19;
    localparam int unsigned FIELD_W = 7;

    typedef enum logic [1:0]
    {
        FLD_NONE,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND
    } field_sel_t;

    typedef struct packed
    {
        logic is_digit;
        logic is_space;
        logic is_colon;
        logic is_dot;
        logic field_full;
        logic out_full;
    } dp_status_t;

    typedef struct packed
    {
        field_sel_t start_sel;
        field_sel_t add_sel;
        logic       add_frac;
        logic       step_mins;
        logic       step_secs;
        logic       step_out;
        logic       parse_ok;
    } dp_cmd_t;

    function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] place);
        logic [FRAC_W-1:0] w;
        case (place)
            3'd0:    w = 20'd100000;
            3'd1:    w = 20'd10000;
            3'd2:    w = 20'd1000;
            3'd3:    w = 20'd100;
            3'd4:    w = 20'd10;
            3'd5:    w = 20'd1;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/tdp_datapath.sv */
`default_nettype none
module tdp_datapath
    import tdp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        char_code,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic [TIME_W-1:0]      time_micros,
    output logic                   valid_res,
    output logic                   out_valid,
    input  wire logic              out_ready
);

    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [FIELD_W-1:0] second_reg, second_next;
    logic [1:0]         digits_reg, digits_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [2:0]         place_reg, place_next;
    logic [MINS_W-1:0]  mins_reg, mins_next;
    logic [SECS_W-1:0]  secs_reg, secs_next;
    logic               range_ok_reg, range_ok_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               valid_res_reg, valid_res_next;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         digit;
    logic [23:0]        frac_term;
    logic [TIME_W-1:0]  time_full;

    function automatic logic [FIELD_W-1:0] append_digit(input logic [FIELD_W-1:0] f,
                                                        input logic [3:0] d);
        logic [10:0] w;
        w = {4'b0, f} * 11'd10 + {7'b0, d};
        return w[FIELD_W-1:0];
    endfunction

    assign digit = char_code[3:0];

    always_comb
    begin
        status.is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        status.is_space   = (char_code == CHAR_SPACE) ||
                            ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
        status.is_colon   = (char_code == CHAR_COLON);
        status.is_dot     = (char_code == CHAR_DOT);
        status.field_full = (digits_reg == 2'd2);
        status.out_full   = out_valid_reg;
    end

    assign frac_term = {20'b0, digit} * {4'b0, frac_weight(place_reg)};
    assign time_full = {18'b0, secs_reg} * 37'd1000000 + {17'b0, frac_reg};

    always_comb
    begin
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        digits_next    = digits_reg;
        frac_next      = frac_reg;
        place_next     = place_reg;
        mins_next      = mins_reg;
        secs_next      = secs_reg;
        range_ok_next  = range_ok_reg;
        time_next      = time_reg;
        valid_res_next = valid_res_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (cmd.start_sel)
            FLD_HOUR:   hour_next   = {3'b0, digit};
            FLD_MINUTE: minute_next = {3'b0, digit};
            FLD_SECOND: second_next = {3'b0, digit};
            default:    ;
        endcase
        case (cmd.add_sel)
            FLD_HOUR:   hour_next   = append_digit(hour_reg, digit);
            FLD_MINUTE: minute_next = append_digit(minute_reg, digit);
            FLD_SECOND: second_next = append_digit(second_reg, digit);
            default:    ;
        endcase

        if (cmd.start_sel != FLD_NONE)
            digits_next = 2'd1;
        else if (cmd.add_sel != FLD_NONE)
            digits_next = digits_reg + 2'd1;

        if (cmd.add_frac && (place_reg < FRAC_PLACES))
        begin
            frac_next  = frac_reg + frac_term[FRAC_W-1:0];
            place_next = place_reg + 3'd1;
        end

        if (cmd.step_mins)
        begin
            mins_next     = {6'b0, hour_reg} * 13'd60 + {6'b0, minute_reg};
            range_ok_next = cmd.parse_ok && (hour_reg <= HOUR_MAX) &&
                            (minute_reg <= MINUTE_MAX) && (second_reg <= MINUTE_MAX);
        end

        if (cmd.step_secs)
            secs_next = {6'b0, mins_reg} * 19'd60 + {12'b0, second_reg};

        if (cmd.step_out)
        begin
            time_next      = range_ok_reg ? time_full : '0;
            valid_res_next = range_ok_reg;
            out_valid_next = 1'b1;
            hour_next      = '0;
            minute_next    = '0;
            second_next    = '0;
            digits_next    = '0;
            frac_next      = '0;
            place_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            digits_reg    <= '0;
            frac_reg      <= '0;
            place_reg     <= '0;
            range_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            digits_reg    <= digits_next;
            frac_reg      <= frac_next;
            place_reg     <= place_next;
            range_ok_reg  <= range_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mins_reg      <= mins_next;
        secs_reg      <= secs_next;
        time_reg      <= time_next;
        valid_res_reg <= valid_res_next;
    end

    assign time_micros = time_reg;
    assign valid_res   = valid_res_reg;
    assign out_valid   = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/tdp_control.sv */
`default_nettype none
module tdp_control
    import tdp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_last,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0]
    {
        ST_SKIP,
        ST_HOUR,
        ST_MIN_START,
        ST_MIN,
        ST_SEC_START,
        ST_SEC,
        ST_FRAC,
        ST_DONE,
        ST_FAIL,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3
    } state_t;

    state_t state_reg, state_next, parse_next;
    logic   ok_reg, ok_next;
    logic   fire;
    dp_cmd_t parse_cmd;

    assign in_ready = (state_reg != ST_MUL1) && (state_reg != ST_MUL2) &&
                      (state_reg != ST_MUL3);
    assign fire = in_valid && in_ready;

    // next parse phase and field commands for the current character
    always_comb
    begin
        parse_next = state_reg;
        parse_cmd  = '0;
        case (state_reg)
            ST_SKIP:
            begin
                if (status.is_digit)
                begin
                    parse_cmd.start_sel = FLD_HOUR;
                    parse_next = ST_HOUR;
                end
                else if (!status.is_space)
                    parse_next = ST_FAIL;
            end
            ST_HOUR:
            begin
                if (status.is_colon)
                    parse_next = ST_MIN_START;
                else if (status.is_digit && !status.field_full)
                    parse_cmd.add_sel = FLD_HOUR;
                else
                    parse_next = ST_FAIL;
            end
            ST_MIN_START:
            begin
                if (status.is_digit)
                begin
                    parse_cmd.start_sel = FLD_MINUTE;
                    parse_next = ST_MIN;
                end
                else
                    parse_next = ST_FAIL;
            end
            ST_MIN:
            begin
                if (status.is_colon)
                    parse_next = ST_SEC_START;
                else if (status.is_digit && !status.field_full)
                    parse_cmd.add_sel = FLD_MINUTE;
                else
                    parse_next = ST_FAIL;
            end
            ST_SEC_START:
            begin
                if (status.is_digit)
                begin
                    parse_cmd.start_sel = FLD_SECOND;
                    parse_next = ST_SEC;
                end
                else
                    parse_next = ST_FAIL;
            end
            ST_SEC:
            begin
                if (status.is_dot)
                    parse_next = ST_FRAC;
                else if (status.is_digit && !status.field_full)
                    parse_cmd.add_sel = FLD_SECOND;
                else
                    parse_next = ST_DONE;
            end
            ST_FRAC:
            begin
                if (status.is_digit)
                    parse_cmd.add_frac = 1'b1;
                else
                    parse_next = ST_DONE;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        case (state_reg)
            ST_MUL1:
            begin
                cmd.step_mins = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.step_secs = 1'b1;
                state_next    = ST_MUL3;
            end
            ST_MUL3:
            begin
                if (!status.out_full)
                begin
                    cmd.step_out = 1'b1;
                    state_next   = ST_SKIP;
                end
            end
            default:
            begin
                if (fire)
                begin
                    cmd = parse_cmd;
                    if (in_last)
                    begin
                        state_next = ST_MUL1;
                        ok_next    = (parse_next == ST_SEC) || (parse_next == ST_FRAC) ||
                                     (parse_next == ST_DONE);
                    end
                    else
                        state_next = parse_next;
                end
            end
        endcase
        cmd.parse_ok = ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SKIP;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/time_of_day_text_parser.sv */
// Channel  Dir  Signals                        Item
// s_       in   s_tvalid s_tready s_tdata      one character; s_tlast ends the string
//                 s_tlast
// m_       out  m_tvalid m_tready m_tdata      one result per string
//                 m_tuser
//
// One character per cycle while a string is being read.
// After the last character the controller steps through the multiply
// chain (h*60+m, *60+s, *1000000+frac) in states MUL1, MUL2 and MUL3,
// one register per multiply.
// The result sits in an output register; the next string is read while it
// waits, and the chain stalls in its final step only while that register is full.
// Asynchronous active-low reset returns the parser to whitespace skipping.
`default_nettype none
module time_of_day_text_parser
    import tdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [36:0] time_micros, [39:37] zero
    output logic             m_tuser    // [0] valid_res
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [TIME_W-1:0] time_micros;

    tdp_control u_control
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdp_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .time_micros (time_micros),
        .valid_res   (m_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata = {3'b0, time_micros};

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0))
        else $error("invalid result carries non-zero time");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata < 40'd86400000000))
        else $error("time beyond one day");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken during result computation");

endmodule
`default_nettype wire
